>>> hw/rtl/rsa_modular_exponentiation_defines.svh
// assertion macros shared by the modular exponentiation rtl
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define RSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define RSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/rsa_me_pkg.sv
// shared types and constants for the modular exponentiation block
`timescale 1ns / 1ps

package rsa_me_pkg;

    // data word and exponent scan length
    localparam int DATA_W    = 32;
    localparam int WORD_BITS = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int IDX_W     = 2;

    // exponent bits at or above the scan length are ignored
    localparam logic [DATA_W-1:0] EXP_MASK =
        (DATA_W'(1) << WORD_BITS) - DATA_W'(1);

    // register reset values
    localparam logic [DATA_W-1:0] MODULUS_RST = DATA_W'(3233);
    localparam logic [DATA_W-1:0] PUB_EXP_RST = DATA_W'(17);
    localparam logic [DATA_W-1:0] PRV_EXP_RST = DATA_W'(2753);

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PUB_EXP = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PRV_EXP = 2'd2;

    // opcode values
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_GO,
        S_RED_WAIT,
        S_STEP,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_DONE
    } rsa_me_state_t;

    // request to the multiply and reduce unit
    typedef struct packed {
        logic              go;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } rsa_me_req_t;

    // response from the multiply and reduce unit
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } rsa_me_rsp_t;

endpackage

>>> hw/rtl/rsa_me_modred.sv
// shared multiply and bit-serial modular reduction unit
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_defines.svh"

module rsa_me_modred (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rsa_me_pkg::rsa_me_req_t             req,
    input  logic [rsa_me_pkg::DATA_W-1:0]       n,
    output rsa_me_pkg::rsa_me_rsp_t             rsp
);
    import rsa_me_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              active_reg;
    logic              active_next;
    logic              done_reg;
    logic              done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // one restoring step: shift in the next product bit, subtract if it fits
    assign trial = {rem_reg, prod_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, n};

    always_comb
    begin
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (req.go)
        begin
            prod_next   = PROD_W'(req.a) * PROD_W'(req.b);
            rem_next    = '0;
            cnt_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            prod_next = {prod_reg[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, n})
            begin
                rem_next = diff[DATA_W-1:0];
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(PROD_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    // checks
    `RSA_ASSERT_IMPLIES(a_no_go_while_active, clk, rst_n, active_reg, !req.go)
    `RSA_ASSERT_NEXT(a_done_single_pulse, clk, rst_n, done_reg, !done_reg)
    `RSA_ASSERT_IMPLIES(a_done_after_active, clk, rst_n, done_reg, !active_reg)

endmodule

>>> hw/rtl/rsa_me_seq.sv
// square-and-multiply sequencer driving the shared reduction unit
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_defines.svh"

module rsa_me_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            opcode,
    input  logic [rsa_me_pkg::DATA_W-1:0]   message,
    input  logic [rsa_me_pkg::DATA_W-1:0]   modulus,
    input  logic [rsa_me_pkg::DATA_W-1:0]   public_exponent,
    input  logic [rsa_me_pkg::DATA_W-1:0]   private_exponent,
    input  rsa_me_pkg::rsa_me_rsp_t         rsp,
    output rsa_me_pkg::rsa_me_req_t         req,
    output logic                            busy,
    output logic                            done,
    output logic [rsa_me_pkg::DATA_W-1:0]   outcome
);
    import rsa_me_pkg::*;

    rsa_me_state_t     state_reg;
    rsa_me_state_t     state_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] sq_reg;
    logic [DATA_W-1:0] exp_reg;
    logic              small_mod;

    // modulus zero or one gives zero for every message
    assign small_mod = (modulus < DATA_W'(2));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = small_mod ? S_DONE : S_RED_GO;
                end
            end
            S_RED_GO:   state_next = S_RED_WAIT;
            S_RED_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (exp_reg[0])
                begin
                    state_next = S_MUL_GO;
                end
                else
                begin
                    state_next = S_SQR_GO;
                end
            end
            S_MUL_GO:   state_next = S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    // last set bit consumed: the remaining square is unused
                    state_next = (exp_reg[DATA_W-1:1] == '0) ? S_DONE : S_SQR_GO;
                end
            end
            S_SQR_GO:   state_next = S_SQR_WAIT;
            S_SQR_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = S_STEP;
                end
            end
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs and operand selection
    always_comb
    begin
        req.go = 1'b0;
        req.a  = acc_reg;
        req.b  = sq_reg;
        case (state_reg)
            S_RED_GO:
            begin
                req.go = 1'b1;
                req.a  = sq_reg;
                req.b  = DATA_W'(1);
            end
            S_MUL_GO:
            begin
                req.go = 1'b1;
                req.a  = acc_reg;
                req.b  = sq_reg;
            end
            S_SQR_GO:
            begin
                req.go = 1'b1;
                req.a  = sq_reg;
                req.b  = sq_reg;
            end
            default:
            begin
                req.go = 1'b0;
            end
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = (state_reg == S_DONE);
    assign outcome = acc_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // accumulator, running square and remaining exponent
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    exp_reg <= ((opcode == OP_DECRYPT) ? private_exponent
                                                       : public_exponent) & EXP_MASK;
                    acc_reg <= small_mod ? '0 : DATA_W'(1);
                    sq_reg  <= message;
                end
            end
            S_RED_WAIT:
            begin
                if (rsp.done)
                begin
                    sq_reg <= rsp.rem;
                end
            end
            S_MUL_WAIT:
            begin
                if (rsp.done)
                begin
                    acc_reg <= rsp.rem;
                end
            end
            S_SQR_WAIT:
            begin
                if (rsp.done)
                begin
                    sq_reg  <= rsp.rem;
                    exp_reg <= exp_reg >> 1;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // checks
    `RSA_ASSERT_NEXT(a_start_sets_busy, clk, rst_n, start && !busy, busy)
    `RSA_ASSERT_NEXT(a_done_returns_idle, clk, rst_n, done, !busy && !done)
    `RSA_ASSERT_IMPLIES(a_go_not_while_done, clk, rst_n, req.go, !rsp.done && busy)

endmodule

>>> hw/rtl/rsa_modular_exponentiation.sv
// one initial reduction of the message, then per exponent bit a multiply if set and a square,
//   the last square skipped after the final set bit; a zero exponent needs only the reduction
// each modular product: load, 64 one-bit reduction steps, done
// one word at a time, next start taken the cycle after done
// reset: modulus 3233, public exponent 17, private exponent 2753, sequencer idle
// result on outcome for one cycle with done; modulus below two goes straight from idle to done; no stall
`timescale 1ns / 1ps

module rsa_modular_exponentiation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [rsa_me_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rsa_me_pkg::DATA_W-1:0]     cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [rsa_me_pkg::DATA_W-1:0]     message,
    output logic                              done,
    output logic [rsa_me_pkg::DATA_W-1:0]     outcome
);
    import rsa_me_pkg::*;

    logic [DATA_W-1:0] modulus_reg;
    logic [DATA_W-1:0] pub_exp_reg;
    logic [DATA_W-1:0] prv_exp_reg;
    rsa_me_req_t       unit_req;
    rsa_me_rsp_t       unit_rsp;

    // configuration registers, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RST;
            pub_exp_reg <= PUB_EXP_RST;
            prv_exp_reg <= PRV_EXP_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data;
                CFG_PUB_EXP: pub_exp_reg <= cfg_data;
                CFG_PRV_EXP: prv_exp_reg <= cfg_data;
                default:     modulus_reg <= modulus_reg;
            endcase
        end
    end

    // sequencer
    rsa_me_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .opcode           (opcode),
        .message          (message),
        .modulus          (modulus_reg),
        .public_exponent  (pub_exp_reg),
        .private_exponent (prv_exp_reg),
        .rsp              (unit_rsp),
        .req              (unit_req),
        .busy             (busy),
        .done             (done),
        .outcome          (outcome)
    );

    // shared multiply and reduce unit
    rsa_me_modred u_modred (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .n     (modulus_reg),
        .rsp   (unit_rsp)
    );

endmodule

>>> tb/sv/rsa_modular_exponentiation_checker.sv
// checker: predicts modular exponentiation results and compares them with the block
`timescale 1ns / 1ps

module rsa_modular_exponentiation_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [rsa_me_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rsa_me_pkg::DATA_W-1:0]     cfg_data,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              opcode,
    input  logic [rsa_me_pkg::DATA_W-1:0]     message,
    input  logic                              done,
    input  logic [rsa_me_pkg::DATA_W-1:0]     outcome,
    output int                                mismatches,
    output int                                waiting,
    output int                                compared
);
    import rsa_me_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // one accepted word and the outcome it should produce
    typedef struct {
        logic              op;
        logic [DATA_W-1:0] msg;
        logic [DATA_W-1:0] value;
    } expected_word_t;

    expected_word_t    expected_q[$];
    logic [DATA_W-1:0] mod_reg;
    logic [DATA_W-1:0] pub_reg;
    logic [DATA_W-1:0] prv_reg;
    int                fail_cnt;
    int                cmp_cnt;

    // right-to-left square and multiply, products kept at full width
    function automatic logic [DATA_W-1:0] modexp_predict(
        input logic [DATA_W-1:0] base,
        input logic [DATA_W-1:0] power,
        input logic [DATA_W-1:0] n
    );
        logic [PROD_W-1:0] prod;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sq;
        if (n < DATA_W'(2))
            return '0;
        acc = DATA_W'(1);
        sq  = base % n;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (i < DATA_W && power[i])
            begin
                prod = PROD_W'(acc) * PROD_W'(sq);
                acc  = DATA_W'(prod % PROD_W'(n));
            end
            prod = PROD_W'(sq) * PROD_W'(sq);
            sq   = DATA_W'(prod % PROD_W'(n));
        end
        return acc;
    endfunction

    // register shadow, word prediction and result comparison
    always @(posedge clk or negedge rst_n)
    begin
        expected_word_t exp_w;
        if (!rst_n)
        begin
            mod_reg = MODULUS_RST;
            pub_reg = PUB_EXP_RST;
            prv_reg = PRV_EXP_RST;
            expected_q.delete();
            fail_cnt = 0;
            cmp_cnt  = 0;
            mismatches <= 0;
            waiting    <= 0;
            compared   <= 0;
        end
        else
        begin
            // register writes, unused index is dropped
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MODULUS: mod_reg = cfg_data;
                    CFG_PUB_EXP: pub_reg = cfg_data;
                    CFG_PRV_EXP: prv_reg = cfg_data;
                    default: ;
                endcase
            end

            // accepted word
            if (start && !busy)
            begin
                exp_w.op    = opcode;
                exp_w.msg   = message;
                exp_w.value = modexp_predict(message,
                    (opcode == OP_DECRYPT) ? prv_reg : pub_reg, mod_reg);
                expected_q.push_back(exp_w);
            end

            // result strobe against the oldest expectation
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("%0t: unexpected result %h with no word waiting",
                            $realtime, outcome);
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    cmp_cnt++;
                    if (outcome !== exp_w.value)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT)
                            $display("%0t: outcome op=%0d message=%h expected %h actual %h",
                                $realtime, exp_w.op, exp_w.msg, exp_w.value, outcome);
                    end
                end
            end

            mismatches <= fail_cnt;
            waiting    <= expected_q.size();
            compared   <= cmp_cnt;
        end
    end

endmodule

>>> tb/sv/rsa_modular_exponentiation_tb.sv
// testbench top: drives words and register settings into the modular exponentiation block
`timescale 1ns / 1ps

module rsa_modular_exponentiation_tb;

    import rsa_me_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 25;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 100;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic              start;
    logic              busy;
    logic              opcode;
    logic [DATA_W-1:0] message;
    logic              done;
    logic [DATA_W-1:0] outcome;

    int mismatches;
    int waiting;
    int compared;
    int words_sent;
    int settings_applied;

    always #2 clk = ~clk;

    rsa_modular_exponentiation DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .message      (message),
        .done         (done),
        .outcome      (outcome)
    );

    rsa_modular_exponentiation_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .message      (message),
        .done         (done),
        .outcome      (outcome),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .compared     (compared)
    );

    // idle gap after a word: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(40, 250);
    endfunction

    // message value, biased toward the modulus boundary
    function automatic logic [DATA_W-1:0] pick_message(input logic [DATA_W-1:0] n);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return DATA_W'(1);
            2:       return n - DATA_W'(1);
            3:       return n;
            4:       return n + DATA_W'(1);
            5:       return (n != '0) ? DATA_W'($urandom) % n : DATA_W'($urandom);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(input logic op, input logic [DATA_W-1:0] msg, input bit steady);
        int gap;
        opcode  <= op;
        message <= msg;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop start, wait for every result and for the block to go idle
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // write all three registers back to back, optionally the unused index too
    task automatic program_regs(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] e,
                                input logic [DATA_W-1:0] d, input bit poke_unused);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_MODULUS;
        cfg_data     <= n;
        @(posedge clk);
        cfg_index <= CFG_PUB_EXP;
        cfg_data  <= e;
        @(posedge clk);
        cfg_index <= CFG_PRV_EXP;
        cfg_data  <= d;
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        cfg_data     <= DATA_W'($urandom);
        settings_applied++;
    endtask

    // one random setting followed by a batch of words
    task automatic random_phase();
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] d;
        int                shape;
        bit                steady;
        n = DATA_W'($urandom) | 32'h8000_0000;
        e = DATA_W'($urandom);
        d = DATA_W'($urandom);
        shape = $urandom_range(0, 5);
        case (shape)
            0: ;
            1: n = DATA_W'($urandom_range(2, 65535));
            2:
            begin
                n = DATA_W'($urandom);
                e = DATA_W'($urandom_range(0, 255));
                d = DATA_W'($urandom_range(0, 255));
            end
            3:
            begin
                n = DATA_W'($urandom) | DATA_W'(1);
                e = DATA_W'(65537);
            end
            4:
            begin
                n = $urandom_range(0, 1) ? 32'hFFFF_FFFF : DATA_W'(2);
                e = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
                d = $urandom_range(0, 1) ? 32'hFFFF_FFFF : DATA_W'(1);
            end
            default:
            begin
                n = DATA_W'($urandom);
                if (n < DATA_W'(2))
                    n = DATA_W'(2);
            end
        endcase
        steady = ($urandom_range(0, 3) == 0);
        program_regs(n, e, d, shape == 5);
        for (int i = 0; i < WORDS_PER_PHASE; i++)
            send_word(1'($urandom_range(0, 1)), pick_message(n), steady);
        drain_block();
    endtask

    // give up on a hung run
    initial
    begin
        #25_000_000;
        $display("Mismatches found");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int drain_cnt;
        words_sent       = 0;
        settings_applied = 0;
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_MODULUS;
        cfg_data     <= '0;
        start        <= 1'b0;
        opcode       <= OP_ENCRYPT;
        message      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset keys: boundaries around the modulus and both opcodes
        send_word(OP_ENCRYPT, DATA_W'(0), 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(1), 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(65), 1'b0);
        send_word(OP_DECRYPT, DATA_W'(2790), 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(3232), 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(3233), 1'b0);
        send_word(OP_DECRYPT, DATA_W'(3234), 1'b0);
        send_word(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
        send_word(OP_DECRYPT, 32'hFFFF_FFFF, 1'b0);
        send_word(OP_DECRYPT, DATA_W'(0), 1'b0);
        drain_block();

        // largest modulus, all-ones exponent and zero exponent
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0);
        send_word(OP_ENCRYPT, 32'hFFFF_FFFE, 1'b0);
        send_word(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(2), 1'b0);
        send_word(OP_DECRYPT, DATA_W'(12345), 1'b0);
        send_word(OP_ENCRYPT, 32'h8000_0000, 1'b0);
        drain_block();

        // smallest legal modulus with exponents zero and one
        program_regs(DATA_W'(2), '0, DATA_W'(1), 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(0), 1'b1);
        send_word(OP_ENCRYPT, DATA_W'(3), 1'b1);
        send_word(OP_DECRYPT, DATA_W'(3), 1'b1);
        send_word(OP_DECRYPT, 32'hFFFF_FFFE, 1'b1);
        drain_block();

        // modulus one gives zero for any exponent
        program_regs(DATA_W'(1), DATA_W'(5), '0, 1'b0);
        send_word(OP_ENCRYPT, DATA_W'(7), 1'b0);
        send_word(OP_DECRYPT, DATA_W'(7), 1'b0);
        drain_block();

        // modulus zero, plus a write to the unused index that must be ignored
        program_regs('0, DATA_W'(9), DATA_W'(3), 1'b1);
        send_word(OP_ENCRYPT, DATA_W'(7), 1'b0);
        send_word(OP_DECRYPT, '0, 1'b0);
        drain_block();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase();

        // final drain with a bound, then a quiet tail
        drain_cnt = 0;
        while (waiting != 0 && drain_cnt < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cnt++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d words over %0d register settings, %0d results compared",
            words_sent, settings_applied, compared);
        $display("summary: moduli 0, 1, 2 and up to 2^32-1, exponents 0 to all ones");
        if (waiting != 0)
            $display("results still missing: %0d", waiting);
        if (mismatches == 0 && waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
